// ----- design/pts_pkg.sv -----
// Package for the PWM tone sweep generator: constants, request codes and the
// structs passed between the top level and the sweep sequencer. No dependencies.
`default_nettype none
package pts_pkg;

   localparam int CountBits = 24;
   localparam int NumBits   = 40;
   localparam int DenBits   = 28;
   localparam int CsrBits   = 28;

   localparam logic [25:0] MicrosMax = 26'h3FFFFFF;
   localparam logic [11:0] DivMin    = 12'd16;
   localparam logic [11:0] DivMax    = 12'd4080;
   localparam logic [16:0] OneQ16    = 17'd65536;
   // ceil(2^28 / 100), exact for dividends below 2^21
   localparam logic [23:0] DutyRecip = 24'd2684355;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_ABORT = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_CLOCK_HZ    = 3'd0,
      CSR_AUDIO_RATE  = 3'd1,
      CSR_CHUNK_LEN   = 3'd2,
      CSR_VOL_LEVEL   = 3'd3,
      CSR_OUT_EN      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [27:0] clock_hz;
      logic [16:0] audio_rate;
      logic [15:0] chunk_length;
      logic [1:0]  volume_level;
      logic        output_enabled;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [15:0]          start_frequency;
      logic [15:0]          end_frequency;
      logic [CountBits-1:0] sweep_length;
      logic [CountBits-1:0] start_offset;
      logic [16:0]          start_volume;
      logic [16:0]          end_volume;
   } req_type;

   typedef struct packed {
      logic [11:0] clock_divider;
      logic [15:0] wrap_value;
      logic [15:0] duty_level;
      logic        silent;
      logic [25:0] chunk_micros;
      logic        finished;
      logic        aborted;
   } res_type;

endpackage
`default_nettype wire

// ----- design/pts_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on pts_pkg for operand widths.
`default_nettype none
module pts_div (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire [pts_pkg::NumBits-1:0]  num,
   input  wire [pts_pkg::DenBits-1:0]  den,
   output logic                        done,
   output logic [pts_pkg::NumBits-1:0] quo
);
   import pts_pkg::*;

   localparam int CntBits = $clog2(NumBits + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [DenBits:0]    rem_ff, rem_in;
   logic [NumBits-1:0]  quo_ff, quo_in;
   logic [DenBits-1:0]  den_ff, den_in;
   logic [DenBits:0]    rem_sh;
   logic                ge;

   assign rem_sh = {rem_ff[DenBits-1:0], quo_ff[NumBits-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(NumBits);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_in = {quo_ff[NumBits-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

// ----- design/pts_seq.sv -----
// Sweep state and sequencer: walks each playing tick through the shared
// multiplier and the shared divider (pts_div). Depends on pts_pkg.
`default_nettype none
module pts_seq (
   input  wire               clock,
   input  wire               reset,
   input  pts_pkg::cfg_type  cfg,
   input  wire               req_valid,
   output logic              req_ready,
   input  pts_pkg::req_type  req,
   output logic              res_valid,
   input  wire               res_ready,
   output pts_pkg::res_type  res
);
   import pts_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_PGO, S_PWAIT, S_MF0, S_MF1, S_MV0, S_MV1, S_USM, S_UGO, S_UWAIT,
      S_DGO, S_DWAIT, S_WM, S_WGO, S_WWAIT, S_DM, S_DQ, S_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic                 active_ff, active_in;
   logic [CountBits-1:0] done_ff, done_in, total_ff, total_in;
   logic [15:0]          ffrom_ff, ffrom_in, fto_ff, fto_in;
   logic [16:0]          vfrom_ff, vfrom_in, vto_ff, vto_in;
   logic [15:0]          top_ff, top_in;
   logic [15:0]          chunk_ff, chunk_in;
   logic [16:0]          p_ff, p_in;
   logic [34:0]          acc_ff, acc_in;
   logic [15:0]          freq_ff, freq_in;
   logic [16:0]          vol_ff, vol_in;
   logic [20:0]          d_ff, d_in;
   logic [NumBits-1:0]   num_ff, num_in;
   logic [DenBits-1:0]   den_ff, den_in;
   logic [11:0]          cdiv_ff, cdiv_in;
   logic [15:0]          duty_ff, duty_in;
   logic [25:0]          us_ff, us_in;
   logic                 sil_ff, sil_in, fin_ff, fin_in, abt_ff, abt_in;

   logic                 div_start, div_done;
   logic [NumBits-1:0]   div_num, div_quo;
   logic [DenBits-1:0]   div_den;
   logic [23:0]          mul_a, mul_b;
   logic [47:0]          prod;

   logic [27:0]          clk_hz;
   logic [16:0]          rate;
   logic [15:0]          clen;
   logic [CountBits-1:0] remain;
   logic [CountBits-1:0] center;
   logic [16:0]          vol_sat;
   logic [NumBits-1:0]   wq;

   assign clk_hz = (cfg.clock_hz == '0) ? 28'd1 : cfg.clock_hz;
   assign rate   = (cfg.audio_rate == '0) ? 17'd1 : cfg.audio_rate;
   assign clen   = (cfg.chunk_length == '0) ? 16'd1 : cfg.chunk_length;
   assign remain = total_ff - done_ff;
   assign center = done_ff + CountBits'(chunk_ff >> 1);
   assign vol_sat = (vol_ff > OneQ16) ? OneQ16 : vol_ff;
   assign wq = (div_quo == '0) ? NumBits'(0) : (div_quo - 1'b1);

   pts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MF0: begin mul_a = 24'(ffrom_ff); mul_b = 24'(OneQ16 - p_ff); end
         S_MF1: begin mul_a = 24'(fto_ff);   mul_b = 24'(p_ff);          end
         S_MV0: begin mul_a = 24'(vfrom_ff); mul_b = 24'(OneQ16 - p_ff); end
         S_MV1: begin mul_a = 24'(vto_ff);   mul_b = 24'(p_ff);          end
         S_USM: begin mul_a = 24'(chunk_ff); mul_b = 24'd1000000;        end
         S_WM:  begin mul_a = 24'(freq_ff);  mul_b = 24'(cdiv_ff);       end
         S_DM:  begin mul_a = 24'(top_ff);   mul_b = 24'(d_ff);          end
         S_DQ:  begin mul_a = num_ff[23:0];  mul_b = DutyRecip;          end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;  active_in = active_ff;
      done_in = done_ff;    total_in = total_ff;
      ffrom_in = ffrom_ff;  fto_in = fto_ff;
      vfrom_in = vfrom_ff;  vto_in = vto_ff;
      top_in = top_ff;      chunk_in = chunk_ff;
      p_in = p_ff;          acc_in = acc_ff;
      freq_in = freq_ff;    vol_in = vol_ff;
      d_in = d_ff;          num_in = num_ff;
      den_in = den_ff;      cdiv_in = cdiv_ff;
      duty_in = duty_ff;    us_in = us_ff;
      sil_in = sil_ff;      fin_in = fin_ff;
      abt_in = abt_ff;
      div_start = 1'b0;
      div_num = num_ff;
      div_den = den_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // every result defaults to the silent form
               cdiv_in = DivMin; duty_in = '0; us_in = '0;
               sil_in = 1'b1; fin_in = 1'b0; abt_in = 1'b0;
               case (req.req_type)
                  REQ_START: begin
                     if (cfg.output_enabled && req.sweep_length != '0) begin
                        ffrom_in = req.start_frequency;
                        fto_in = req.end_frequency;
                        total_in = req.sweep_length;
                        done_in = req.start_offset;
                        vfrom_in = req.start_volume;
                        vto_in = req.end_volume;
                        active_in = 1'b1;
                     end
                  end
                  REQ_TICK: begin
                     if (!cfg.output_enabled) begin
                        state_in = S_OUT;
                     end else if (!active_ff || done_ff >= total_ff) begin
                        active_in = 1'b0;
                        fin_in = 1'b1;
                        state_in = S_OUT;
                     end else begin
                        chunk_in = (remain > CountBits'(clen)) ? clen : remain[15:0];
                        state_in = S_PGO;
                     end
                  end
                  REQ_ABORT: begin
                     abt_in = active_ff;
                     active_in = 1'b0;
                     state_in = S_OUT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PGO: begin
            div_start = 1'b1;
            div_num = {center, 16'b0};
            div_den = DenBits'(total_ff);
            done_in = done_ff + CountBits'(chunk_ff);
            state_in = S_PWAIT;
         end
         S_PWAIT: if (div_done) begin
            p_in = (div_quo > NumBits'(OneQ16)) ? OneQ16 : div_quo[16:0];
            state_in = S_MF0;
         end
         S_MF0: begin acc_in = prod[34:0]; state_in = S_MF1; end
         S_MF1: begin
            freq_in = 16'((acc_ff + prod[34:0] + 35'd32768) >> 16);
            state_in = S_MV0;
         end
         S_MV0: begin acc_in = prod[34:0]; state_in = S_MV1; end
         S_MV1: begin
            vol_in = 17'((acc_ff + prod[34:0]) >> 16);
            state_in = S_USM;
         end
         S_USM: begin
            num_in = prod[NumBits-1:0];
            d_in = (21'(vol_sat) << 4) + (21'(vol_sat) << 1);
            state_in = S_UGO;
         end
         S_UGO: begin
            div_start = 1'b1;
            div_den = DenBits'(rate);
            state_in = S_UWAIT;
         end
         S_UWAIT: if (div_done) begin
            us_in = (div_quo > NumBits'(MicrosMax)) ? MicrosMax : div_quo[25:0];
            if (freq_ff == '0 || vol_ff == '0) begin
               state_in = S_OUT;
            end else begin
               sil_in = 1'b0;
               state_in = S_DGO;
            end
         end
         S_DGO: begin
            div_start = 1'b1;
            div_num = NumBits'(clk_hz);
            div_den = {freq_ff, 12'b0};
            state_in = S_DWAIT;
         end
         S_DWAIT: if (div_done) begin
            if (div_quo < NumBits'(DivMin))      cdiv_in = DivMin;
            else if (div_quo > NumBits'(DivMax)) cdiv_in = DivMax;
            else                                 cdiv_in = div_quo[11:0];
            state_in = S_WM;
         end
         S_WM: begin den_in = prod[DenBits-1:0]; state_in = S_WGO; end
         S_WGO: begin
            div_start = 1'b1;
            div_num = NumBits'({clk_hz, 4'b0});
            state_in = S_WWAIT;
         end
         S_WWAIT: if (div_done) begin
            top_in = (wq > NumBits'(16'hFFFF)) ? 16'hFFFF : wq[15:0];
            state_in = (cfg.volume_level == 2'd1) ? S_DM : S_OUT;
         end
         // divide by 6553600: drop 16 bits here, then multiply by 1/100
         S_DM: begin num_in = {16'b0, prod[39:16]}; state_in = S_DQ; end
         S_DQ: begin
            duty_in = prod[43:28];
            state_in = S_OUT;
         end
         S_OUT: if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= 1'b0;
         done_ff <= '0;  total_ff <= '0;
         ffrom_ff <= '0; fto_ff <= '0;
         vfrom_ff <= '0; vto_ff <= '0;
         top_ff <= '0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         done_ff <= done_in;   total_ff <= total_in;
         ffrom_ff <= ffrom_in; fto_ff <= fto_in;
         vfrom_ff <= vfrom_in; vto_ff <= vto_in;
         top_ff <= top_in;
      end
      chunk_ff <= chunk_in; p_ff <= p_in;   acc_ff <= acc_in;
      freq_ff <= freq_in;   vol_ff <= vol_in; d_ff <= d_in;
      num_ff <= num_in;     den_ff <= den_in; cdiv_ff <= cdiv_in;
      duty_ff <= duty_in;   us_ff <= us_in;   sil_ff <= sil_in;
      fin_ff <= fin_in;     abt_ff <= abt_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);
   assign res.clock_divider = cdiv_ff;
   assign res.wrap_value    = top_ff;
   assign res.duty_level    = duty_ff;
   assign res.silent        = sil_ff;
   assign res.chunk_micros  = us_ff;
   assign res.finished      = fin_ff;
   assign res.aborted       = abt_ff;
endmodule
`default_nettype wire

// ----- design/pwm_tone_sweep_fade_generator_top.sv -----
// Top level of the PWM tone sweep generator: configuration registers, stream
// ports and the result register. Depends on pts_pkg and pts_seq.
//
//   channel   dir   handshake               payload
//   req_      in    tvalid/tready           tdata 120 bits, tuser req_type
//   rsp_      out   tvalid/tready           tdata 72 bits, tuser flags
//   csr_      in    we                      index 3 bits, wdata 28 bits
//
// A start transfer leaves req_tready high; an abort or a tick with nothing to
// play drops it until its result is taken. A playing tick holds it low through
// the multiplier steps and the shared 40-step divider, run four times (twice for
// a silent chunk), and skips the duty steps when the level mutes the duty.
// A result still waiting in the output register holds the sequencer in its last state.
// Reset is synchronous and returns the configuration and result valid registers to their defaults.
`default_nettype none
module pwm_tone_sweep_fade_generator_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // sf[15:0] ef[31:16] sweep_length[55:32] start_offset[79:56]
   // start_volume[96:80] end_volume[113:97], zero fill above
   input  wire  [119:0] req_tdata,
   input  wire  [1:0]   req_tuser,    // req_type
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // clock_divider[11:0] wrap_value[27:12] duty_level[43:28]
   // chunk_micros[69:44], zero fill above
   output logic [71:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser,    // silent[0] finished[1] aborted[2]
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [27:0]  csr_wdata
);
   import pts_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   req_type     req;
   res_type     res;
   logic        res_valid, res_ready;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLOCK_HZ:    cfg_in.clock_hz = csr_wdata;
            CSR_AUDIO_RATE:  cfg_in.audio_rate = csr_wdata[16:0];
            CSR_CHUNK_LEN:   cfg_in.chunk_length = csr_wdata[15:0];
            CSR_VOL_LEVEL:   cfg_in.volume_level = csr_wdata[1:0];
            CSR_OUT_EN:      cfg_in.output_enabled = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign req.req_type        = req_tuser;
   assign req.start_frequency = req_tdata[15:0];
   assign req.end_frequency   = req_tdata[31:16];
   assign req.sweep_length    = req_tdata[55:32];
   assign req.start_offset    = req_tdata[79:56];
   assign req.start_volume    = req_tdata[96:80];
   assign req.end_volume      = req_tdata[113:97];

   pts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // take a new result when the register is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b0, res.chunk_micros, res.duty_level,
                         res.wrap_value, res.clock_divider};
         rsp_user_in  = {res.aborted, res.finished, res.silent};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_hz       <= 28'd125000000;
         cfg_ff.audio_rate     <= 17'd22050;
         cfg_ff.chunk_length   <= 16'd220;
         cfg_ff.volume_level   <= 2'd1;
         cfg_ff.output_enabled <= 1'b1;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

// ----- design/pts_checker.sv -----
// Port-level checks for the PWM tone sweep generator, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module pts_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [71:0]  rsp_tdata,
   input wire [2:0]   rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[43:28] == 16'd0 &&
      rsp_tdata[11:0] == 12'd16)
      else $error("silent result carries a tone");

   a_div: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:0] >= 12'd16 && rsp_tdata[11:0] <= 12'd4080)
      else $error("divider out of range");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |->
      rsp_tuser[0] && !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("inconsistent end flags");

   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result present after reset");
endmodule

bind pwm_tone_sweep_fade_generator_top pts_checker u_pts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
